[hdl/sbsr_pkg.sv]
// Shared types, codes and default sizes for the swap-remove stack.
package sbsr_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

[hdl/sbsr_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface sbsr_in_if;
  import sbsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sbsr_out_if;
  import sbsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  popped_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output popped_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input entry_count,
                  output ready);
endinterface

[hdl/sbsr_store.sv]
// Entry memory: one write port and one read port with registered read data.
module sbsr_store #(
  parameter int DEPTH = sbsr_pkg::CAPACITY_DEF,
  parameter int WIDTH = sbsr_pkg::WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hdl/stack_bag_with_swap_remove_core.sv]
// Top level of the stack with swap-remove: request sequencer and entry store.
//
// Usage: one request enters on in_ch (mode, value) and exactly one response
// leaves on out_ch (status, popped_value, entry_count). A beat moves when valid
// and ready are both high. The block works on one request at a time: in_ch.ready
// is high only while it is idle, and it stays low until the response beat has
// been taken on out_ch.
// A push, a refused request or the unused mode goes from S_DISPATCH straight to the
// response state S_RESP; a pop passes through S_POP to collect the read data, and a
// delete scans the entries from index 0 upward in S_SCAN, then on a match moves the
// top entry in S_TOP. A delete that misses scans every entry before it responds.
// A new request is taken no earlier than the cycle after the response beat, so
// the block never works on two requests at once.
// The delete time is set by the single memory read port and the one comparator,
// which look at one stored entry per cycle.
// Reset empties the store at once; no clearing pass is needed since only entries
// below the fill count are ever used. While the receiver holds out_ch.ready low
// the response stays on the port unchanged and no new request is taken.
module stack_bag_with_swap_remove_core #(
  parameter int CAPACITY  = sbsr_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = sbsr_pkg::WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sbsr_in_if.sink   in_ch,
  sbsr_out_if.source out_ch
);
  import sbsr_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_POP      = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_TOP      = 7'b0010000,
    S_RESP     = 7'b0100000,
    S_SPARE    = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  status_t               status_r, status_nxt;
  logic [VALUE_W-1:0]    popped_r, popped_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  logic [63:0]           value_ext;
  logic [63:0]           rdata_ext;
  logic [CNT_W-1:0]      top_idx;
  logic [31:0]           count_ext;
  logic                  hit;

  assign value_ext = 64'(in_ch.value);
  assign rdata_ext = 64'(mem_rdata);
  assign top_idx   = count_r - 1'b1;
  assign count_ext = 32'(count_r);
  // The one comparator that the delete scan reuses every cycle.
  assign hit       = (mem_rdata == word_r);

  sbsr_store #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    word_nxt   = word_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = word_r;
    mem_raddr  = top_idx[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = mode_t'(in_ch.mode);
          word_nxt  = value_ext[WORD_BITS-1:0];
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_nxt = ST_DONE;
        popped_nxt = '0;
        idx_nxt    = '0;
        state_nxt  = S_RESP;
        case (mode_r)
          MODE_PUSH: begin
            if (count_r == CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              mem_wdata = word_r;
              count_nxt = count_r + 1'b1;
            end
          end
          MODE_POP: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              // The read of the top entry is issued here; data lands next cycle.
              mem_raddr = top_idx[AW-1:0];
              count_nxt = top_idx;
              state_nxt = S_POP;
            end
          end
          MODE_DELETE: begin
            if (count_r == '0) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              mem_raddr = '0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            status_nxt = ST_DONE;
          end
        endcase
      end
      S_POP: begin
        popped_nxt = rdata_ext[VALUE_W-1:0];
        state_nxt  = S_RESP;
      end
      S_SCAN: begin
        // mem_rdata holds the entry at idx_r, read in the previous cycle.
        if (hit) begin
          mem_raddr = top_idx[AW-1:0];
          state_nxt = S_TOP;
        end else if (CNT_W'(idx_r) == top_idx) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt   = AW'(idx_r + 1'b1);
          mem_raddr = AW'(idx_r + 1'b1);
        end
      end
      S_TOP: begin
        // Move the top entry into the matched slot; a match at the top just shrinks.
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        mem_wdata  = mem_rdata;
        count_nxt  = top_idx;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    word_r   <= word_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_RESP);
  assign out_ch.status       = status_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.entry_count  = count_ext[COUNT_W-1:0];
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the swap-remove stack core.
`timescale 1ns / 100ps

module tb_top;
  import sbsr_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_FROM   = 900;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRILL_ROWS   = 22;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] popped;
    logic [COUNT_W-1:0] count;
  } stack_reply_t;

  // A row is repeated reps times, with the value stepped by stride each time.
  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] value;
    logic [4:0]         reps;
    logic [VALUE_W-1:0] stride;
    bit                 typed;
    stack_reply_t       reply;
  } drill_row_t;

  drill_row_t drill_rows [DRILL_ROWS] = '{
    '{MODE_POP,    32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_EMPTY,     32'h0, 5'd0}},
    '{MODE_DELETE, 32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 5'd0}},
    '{MODE_NOP,    32'hFFFF_FFFF, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd0}},
    '{MODE_PUSH,   32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd1}},
    '{MODE_PUSH,   32'hFFFF_FFFF, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd2}},
    '{MODE_PUSH,   32'h8000_0001, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd3}},
    '{MODE_PUSH,   32'h7FFF_FFFE, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd4}},
    '{MODE_DELETE, 32'h8000_0001, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd3}},
    '{MODE_DELETE, 32'h7FFF_FFFE, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd2}},
    '{MODE_DELETE, 32'h1234_5678, 5'd1,  32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 5'd2}},
    '{MODE_DELETE, 32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd1}},
    '{MODE_POP,    32'hFFFF_FFFF, 5'd1,  32'h0, 1'b1, '{ST_DONE, 32'hFFFF_FFFF, 5'd0}},
    '{MODE_PUSH,   32'h0000_0011, 5'd3,  32'h0, 1'b0, '{ST_DONE,      32'h0, 5'd0}},
    '{MODE_DELETE, 32'h0000_0011, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd2}},
    '{MODE_POP,    32'h0000_0000, 5'd2,  32'h0, 1'b0, '{ST_DONE,      32'h0, 5'd0}},
    '{MODE_PUSH,   32'hA5A5_0000, 5'd16, 32'h0101_0101, 1'b0, '{ST_DONE, 32'h0, 5'd0}},
    '{MODE_PUSH,   32'h5A5A_5A5A, 5'd1,  32'h0, 1'b1, '{ST_FULL,      32'h0, 5'd16}},
    '{MODE_NOP,    32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd16}},
    '{MODE_DELETE, 32'hA5A5_0000, 5'd1,  32'h0, 1'b1, '{ST_DONE,      32'h0, 5'd15}},
    '{MODE_DELETE, 32'hB4B4_0F0F, 5'd1,  32'h0, 1'b0, '{ST_DONE,      32'h0, 5'd0}},
    '{MODE_POP,    32'hFFFF_FFFF, 5'd14, 32'h0, 1'b0, '{ST_DONE,      32'h0, 5'd0}},
    '{MODE_POP,    32'h0000_0000, 5'd1,  32'h0, 1'b1, '{ST_EMPTY,     32'h0, 5'd0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbsr_in_if  req_ch ();
  sbsr_out_if rsp_ch ();

  stack_bag_with_swap_remove_core #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS_DEF)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the stack contents, updated at each accepted request.
  logic [VALUE_W-1:0] stack_words [CAPACITY];
  int                 stack_fill = 0;
  stack_reply_t       awaited_replies [$];
  stack_reply_t       want_reply;
  int                 error_count = 0;
  int                 quiet_cycles = 0;

  bit quiet = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;

  function automatic stack_reply_t stack_apply(mode_t m, logic [VALUE_W-1:0] v);
    stack_reply_t reply;
    int           hit;
    reply.status = ST_DONE;
    reply.popped = '0;
    case (m)
      MODE_PUSH: begin
        if (stack_fill >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          stack_words[stack_fill] = v;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          stack_fill--;
          reply.popped = stack_words[stack_fill];
        end
      end
      MODE_DELETE: begin
        hit = -1;
        for (int k = 0; k < stack_fill; k++) begin
          if (hit < 0 && stack_words[k] == v) hit = k;
        end
        if (hit < 0) begin
          reply.status = ST_NOT_FOUND;
        end else begin
          // The top entry fills the hole; deleting the top just shrinks.
          stack_words[hit] = stack_words[stack_fill-1];
          stack_fill--;
        end
      end
      default: ;
    endcase
    reply.count = COUNT_W'(stack_fill);
    return reply;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after the beat.
  task automatic offer_request(mode_t m, logic [VALUE_W-1:0] v, bit typed,
                               stack_reply_t typed_reply);
    stack_reply_t predicted;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode  = m;
    req_ch.value = v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = stack_apply(m, v);
    awaited_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word(logic [VALUE_W-1:0] pool [8]);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return pool[$urandom_range(0, 7)];
    if (r < 55) return '0;
    if (r < 60) return '1;
    return $urandom;
  endfunction

  initial begin
    drill_row_t         row;
    logic [VALUE_W-1:0] pool [8];
    logic [VALUE_W-1:0] v;
    mode_t              m;
    int                 push_pct;
    int                 r;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PUSH;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    for (int k = 0; k < CAPACITY; k++) stack_words[k] = '0;
    for (int k = 0; k < 8; k++) pool[k] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (drill_rows[i]) begin
      row = drill_rows[i];
      for (int n = 0; n < row.reps; n++) begin
        offer_request(row.mode, row.value + n * row.stride, row.typed, row.reply);
      end
    end

    push_pct = 60;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        r = $urandom_range(0, 2);
        send_idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 50;
        r = $urandom_range(0, 2);
        recv_idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 50;
      end
      // Alternate between growing and shrinking so the store swings between empty and full.
      if (i % 40 == 0) push_pct = (push_pct > 50) ? 25 : 70;
      if (i == 300) long_hold_req = 1'b1;
      if (i == QUIET_FROM) quiet = 1'b1;

      r = $urandom_range(0, 99);
      if (r < 3) m = MODE_NOP;
      else if (r < 3 + push_pct) m = MODE_PUSH;
      else if (r % 2 == 0) m = MODE_POP;
      else m = MODE_DELETE;

      v = pick_word(pool);
      if (m == MODE_DELETE && stack_fill > 0 && $urandom_range(0, 99) < 60) begin
        v = stack_words[$urandom_range(0, stack_fill - 1)];
      end
      offer_request(m, v, 1'b0, '0);
    end
    req_ch.valid = 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_ch.ready = 1'b0;
      hold_left--;
    end else if (long_hold_req) begin
      // Keep the response parked long enough that the sender sits stalled on its request.
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      rsp_ch.ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
      hold_left = $urandom_range(0, 11);
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        error_count++;
        $error("response beat with nothing awaited: status %0d count %0d",
               rsp_ch.status, rsp_ch.entry_count);
      end else begin
        want_reply = awaited_replies.pop_front();
        if (rsp_ch.status !== want_reply.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want_reply.status, rsp_ch.status);
        end
        if (rsp_ch.popped_value !== want_reply.popped) begin
          error_count++;
          $error("popped_value: expected %h, got %h", want_reply.popped, rsp_ch.popped_value);
        end
        if (rsp_ch.entry_count !== want_reply.count) begin
          error_count++;
          $error("entry_count: expected %0d, got %0d", want_reply.count, rsp_ch.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
